// ===== rtl/przcm_pkg.sv =====
// Shared constants and types for the peak-region zero-cross mask block.
// No dependencies.
package przcm_pkg;

	localparam int DEPTH       = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int IDX_W       = 12;
	localparam int THR_W       = 15;
	localparam int CMP_W       = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(8192);

	// register index, taken from paddr[2]
	localparam logic REG_PEAK_THRESHOLD = 1'b0;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FWD  = 3'b010,
		ST_BWD  = 3'b100
	} state_t;

	// per-sample run flags written by the forward pass
	typedef struct packed {
		logic mpos;
		logic fpos;
		logic mneg;
		logic fneg;
	} aux_t;

endpackage

// ===== rtl/peak_region_zero_cross_mask.sv =====
// Peak-region zero-cross mask: sample RAM, forward/backward run sequencer, mask RAM.
// Depends on przcm_pkg.
//
// A read result passes through a registered read stage into an output register,
// so the next beat can be taken while it waits. The append marked last starts
// the mask computation: a forward pass over the sample RAM and a backward pass
// over the run-flag RAM, one sample per cycle through one compare/run-flag unit,
// during which in_ready is low. No clearing pass after reset.
module peak_region_zero_cross_mask (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [przcm_pkg::PADDR_W-1:0]         paddr,
	input  logic [przcm_pkg::PDATA_W-1:0]         pwdata,
	output logic [przcm_pkg::PDATA_W-1:0]         prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  operation,
	input  logic signed [przcm_pkg::SAMPLE_BITS-1:0] sample_value,
	input  logic                                  last_sample,
	input  logic [przcm_pkg::IDX_W-1:0]           read_index,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  masked,
	output logic                                  in_range,
	output logic [przcm_pkg::IDX_W-1:0]           index_echo
);
	import przcm_pkg::*;

	logic [THR_W-1:0]        thr_q;
	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic [CNT_W-1:0]        ptr_q;
	logic                    vld_s1;
	logic [ADDR_W-1:0]       idx_s1;
	logic                    fpos_q, fneg_q;
	logic                    hpos_q, hneg_q, nmpos_q, nmneg_q;

	logic signed [SAMPLE_BITS-1:0] sample_store [DEPTH];
	aux_t                          aux_store    [DEPTH];
	logic                          mask_store   [DEPTH];
	logic signed [SAMPLE_BITS-1:0] smp_rd_q;
	aux_t                          aux_rd_q;
	logic                          mask_rd_q;

	logic                    rd_vld_s1;
	logic [IDX_W-1:0]        rd_idx_s1;
	logic                    rd_inr_s1, rd_done_s1;
	logic                    out_valid_q;

	logic                    in_acc, app_acc, rd_acc, s1_move;
	logic [CNT_W-1:0]        wr_idx;
	logic                    smp_we;
	logic                    fwd_issue, bwd_issue, fwd_we, bwd_we;
	logic [ADDR_W-1:0]       bwd_addr;
	logic signed [CMP_W-1:0] xs, thp, thn;
	aux_t                    aux_new;
	logic                    tpos, tneg;
	logic                    cfg_we;

	// configuration
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_PEAK_THRESHOLD) ? PDATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we && paddr[2] == REG_PEAK_THRESHOLD) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	// input handshake
	assign s1_move  = rd_vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = (state_q == ST_IDLE) && (!rd_vld_s1 || s1_move);
	assign in_acc   = in_valid && in_ready;
	assign app_acc  = in_acc && (operation == OP_APPEND);
	assign rd_acc   = in_acc && (operation == OP_READ);
	assign wr_idx   = done_q ? '0 : cnt_q;
	assign smp_we   = app_acc && (wr_idx < CNT_W'(DEPTH));

	// pass sequencing
	assign fwd_issue = (state_q == ST_FWD) && (ptr_q != cnt_q);
	assign bwd_issue = (state_q == ST_BWD) && (ptr_q != '0);
	assign bwd_addr  = ADDR_W'(ptr_q - CNT_W'(1));
	assign fwd_we    = vld_s1 && (state_q == ST_FWD);
	assign bwd_we    = vld_s1 && (state_q == ST_BWD);

	// forward step: run membership, peak compare, running peak flags
	always_comb begin
		xs           = CMP_W'(smp_rd_q);
		thp          = signed'(CMP_W'({1'b0, thr_q}));
		thn          = -thp;
		aux_new.mpos = !smp_rd_q[SAMPLE_BITS-1];
		aux_new.mneg = smp_rd_q[SAMPLE_BITS-1] || (smp_rd_q == '0);
		aux_new.fpos = aux_new.mpos && ((xs > thp) || fpos_q);
		aux_new.fneg = aux_new.mneg && ((xs < thn) || fneg_q);
	end

	// backward step: spread each run's total peak flag over the run
	assign tpos = aux_rd_q.mpos && (nmpos_q ? hpos_q : aux_rd_q.fpos);
	assign tneg = aux_rd_q.mneg && (nmneg_q ? hneg_q : aux_rd_q.fneg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			ptr_q   <= '0;
			vld_s1  <= 1'b0;
			fpos_q  <= 1'b0;
			fneg_q  <= 1'b0;
			hpos_q  <= 1'b0;
			hneg_q  <= 1'b0;
			nmpos_q <= 1'b0;
			nmneg_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (app_acc) begin
						cnt_q  <= smp_we ? wr_idx + CNT_W'(1) : wr_idx;
						done_q <= 1'b0;
						if (last_sample) begin
							state_q <= ST_FWD;
							ptr_q   <= '0;
							fpos_q  <= 1'b0;
							fneg_q  <= 1'b0;
						end
					end
				end
				ST_FWD: begin
					vld_s1 <= fwd_issue;
					if (fwd_issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (fwd_we) begin
						fpos_q <= aux_new.fpos;
						fneg_q <= aux_new.fneg;
					end
					if (!fwd_issue && !vld_s1) begin
						state_q <= ST_BWD;
						ptr_q   <= cnt_q;
						fpos_q  <= 1'b0;
						fneg_q  <= 1'b0;
						hpos_q  <= 1'b0;
						hneg_q  <= 1'b0;
						nmpos_q <= 1'b0;
						nmneg_q <= 1'b0;
					end
				end
				ST_BWD: begin
					vld_s1 <= bwd_issue;
					if (bwd_issue) begin
						ptr_q <= ptr_q - CNT_W'(1);
					end
					if (bwd_we) begin
						hpos_q  <= tpos;
						hneg_q  <= tneg;
						nmpos_q <= aux_rd_q.mpos;
						nmneg_q <= aux_rd_q.mneg;
					end
					if (!bwd_issue && !vld_s1) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fwd_issue) begin
			idx_s1 <= ptr_q[ADDR_W-1:0];
		end else if (bwd_issue) begin
			idx_s1 <= bwd_addr;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (smp_we) begin
			sample_store[wr_idx[ADDR_W-1:0]] <= sample_value;
		end
		if (fwd_issue) begin
			smp_rd_q <= sample_store[ptr_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (fwd_we) begin
			aux_store[idx_s1] <= aux_new;
		end
		if (bwd_issue) begin
			aux_rd_q <= aux_store[bwd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (bwd_we) begin
			mask_store[idx_s1] <= !(tpos || tneg);
		end
		if (rd_acc) begin
			mask_rd_q <= mask_store[read_index[ADDR_W-1:0]];
		end
	end

	// read result path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_acc) begin
				rd_vld_s1 <= 1'b1;
			end else if (s1_move) begin
				rd_vld_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_acc) begin
			rd_idx_s1  <= read_index;
			rd_inr_s1  <= CNT_W'(read_index) < cnt_q;
			rd_done_s1 <= done_q;
		end
		if (s1_move) begin
			masked     <= (rd_inr_s1 && rd_done_s1) ? mask_rd_q : 1'b1;
			in_range   <= rd_inr_s1;
			index_echo <= rd_idx_s1;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= cnt_q)
		else $error("pass pointer beyond record");

	a_fwd_next: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FWD |=> state_q == ST_FWD || state_q == ST_BWD)
		else $error("forward pass left without backward pass");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(state_q) == ST_BWD)
		else $error("record done without backward pass");

	a_s1_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 && !s1_move |-> out_valid_q && !out_ready)
		else $error("read stage stalled with free output");

	a_idle_s1: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !smp_we && !rd_acc)
		else $error("beat taken during mask computation");
`endif

endmodule

// ===== bench/tb.sv =====
// Testbench for peak_region_zero_cross_mask: loads sample records, reads back mask bits,
// and checks every mask reply against a software copy of the run/peak rule.
// Depends on przcm_pkg and the peak_region_zero_cross_mask RTL.
module tb;
	import przcm_pkg::*;

	localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = PADDR_W'({REG_PEAK_THRESHOLD, 2'b00});
	localparam logic [PADDR_W-1:0] ADDR_SPARE     = PADDR_W'({~REG_PEAK_THRESHOLD, 2'b00});
	localparam int STALL_LIMIT = 40000;
	localparam int RANDOM_BEATS = 1050;

	typedef enum bit {REC_LOADING, REC_DONE} rec_phase_t;

	typedef struct {
		logic             masked;
		logic             in_range;
		logic [IDX_W-1:0] index_echo;
	} mask_reply_t;

	class mask_scoreboard;
		logic signed [SAMPLE_BITS-1:0] samples [DEPTH];
		bit               mask_bits [DEPTH];
		int               loaded;
		rec_phase_t       phase;
		logic [THR_W-1:0] threshold;
		mask_reply_t      pending [$];
		int               errors, replies, records, dropped, cfg_writes;

		function new();
			loaded = 0;
			phase = REC_LOADING;
			threshold = THR_RESET;
			errors = 0;
			replies = 0;
			records = 0;
			dropped = 0;
			cfg_writes = 0;
		endfunction

		function void write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
			if (addr == ADDR_THRESHOLD)
				threshold = data[THR_W-1:0];
			cfg_writes++;
		endfunction

		// clear mask over each maximal run (sign selects kind) that holds a peak
		function void clear_peak_runs(bit nonneg);
			int i, j, k, x, thr;
			bit hit;
			thr = int'(threshold);
			i = 0;
			while (i < loaded) begin
				x = int'(samples[i]);
				if (nonneg ? (x < 0) : (x > 0)) begin
					i++;
				end else begin
					j = i;
					hit = 1'b0;
					while (j < loaded) begin
						x = int'(samples[j]);
						if (nonneg ? (x < 0) : (x > 0))
							break;
						if (nonneg ? (x > thr) : (x < -thr))
							hit = 1'b1;
						j++;
					end
					if (hit)
						for (k = i; k < j; k++)
							mask_bits[k] = 1'b0;
					i = j;
				end
			end
		endfunction

		function void note_beat(logic op, logic signed [SAMPLE_BITS-1:0] val, logic last,
				logic [IDX_W-1:0] idx);
			mask_reply_t r;
			int i;
			if (op == OP_APPEND) begin
				if (phase == REC_DONE) begin
					phase = REC_LOADING;
					loaded = 0;
				end
				if (loaded < DEPTH) begin
					samples[loaded] = val;
					loaded++;
				end else begin
					dropped++;
				end
				if (last) begin
					for (i = 0; i < loaded; i++)
						mask_bits[i] = 1'b1;
					clear_peak_runs(1'b1);
					clear_peak_runs(1'b0);
					phase = REC_DONE;
					records++;
				end
			end else begin
				r.in_range = (int'(idx) < loaded);
				r.masked = 1'b1;
				if (r.in_range && phase == REC_DONE)
					r.masked = mask_bits[idx];
				r.index_echo = idx;
				pending = {pending, r};
			end
		endfunction

		function void check_reply(logic m, logic inr, logic [IDX_W-1:0] echo);
			mask_reply_t want;
			if (pending.size() == 0) begin
				$error("mask reply with no read pending: index_echo %0d", echo);
				errors++;
				return;
			end
			want = pending.pop_front();
			replies++;
			if (m !== want.masked) begin
				$error("masked: expected %0b, got %0b (index %0d)", want.masked, m,
					want.index_echo);
				errors++;
			end
			if (inr !== want.in_range) begin
				$error("in_range: expected %0b, got %0b (index %0d)", want.in_range, inr,
					want.index_echo);
				errors++;
			end
			if (echo !== want.index_echo) begin
				$error("index_echo: expected %0d, got %0d", want.index_echo, echo);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;
	logic in_valid, in_ready, operation, last_sample;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic [IDX_W-1:0] read_index;
	logic out_valid, out_ready, masked, in_range;
	logic [IDX_W-1:0] index_echo;

	mask_scoreboard sb;
	bit calm;
	int beats_sent;
	int cfg_errors;
	int idle_cycles;

	peak_region_zero_cross_mask DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] make_sample(int sgn);
		int thr, v, r;
		thr = int'(sb.threshold);
		r = $urandom_range(0, 99);
		if (sgn == 0)
			v = 0;
		else if (r < 8)
			v = int'($urandom);
		else if (r < 12)
			v = (sgn > 0) ? 32767 : -32768;
		else if (r < 30)
			v = (sgn > 0) ? ((thr < 32767) ? int'($urandom_range(32767, thr + 1)) : 32767)
				: -int'($urandom_range(32768, thr + 1));
		else
			v = sgn * ((thr == 0) ? 1 : int'($urandom_range(1, thr)));
		return SAMPLE_BITS'(v);
	endfunction

	function automatic logic [IDX_W-1:0] pick_index();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75 && sb.loaded > 0)
			return IDX_W'($urandom_range(0, sb.loaded - 1));
		if (r < 85)
			return IDX_W'(sb.loaded);
		return IDX_W'($urandom);
	endfunction

	task automatic send_beat(input logic op, input logic signed [SAMPLE_BITS-1:0] val,
			input logic last, input logic [IDX_W-1:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		sample_value <= val;
		last_sample <= last;
		read_index <= idx;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic append(input logic signed [SAMPLE_BITS-1:0] val, input logic last);
		send_beat(OP_APPEND, val, last, IDX_W'($urandom));
	endtask

	task automatic read_mask(input logic [IDX_W-1:0] idx);
		send_beat(OP_READ, SAMPLE_BITS'($urandom), 1'($urandom), idx);
	endtask

	// drain replies, then let a mask pass over the stored record finish
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (2 * sb.loaded + 16) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.write_reg(addr, data);
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] thr, input bit touch_spare);
		logic [PDATA_W-1:0] word, back;
		settle();
		word = $urandom;
		word[THR_W-1:0] = thr;
		apb_write(ADDR_THRESHOLD, word);
		if (touch_spare)
			apb_write(ADDR_SPARE, $urandom);
		apb_read(ADDR_THRESHOLD, back);
		if (back[THR_W-1:0] !== sb.threshold) begin
			$error("prdata: expected %0d, got %0d", sb.threshold, back[THR_W-1:0]);
			cfg_errors++;
		end
	endtask

	task automatic run_record();
		int n, nreads, k, sgn, r;
		r = $urandom_range(0, 99);
		n = (r < 70) ? $urandom_range(1, 16) : (r < 95) ? $urandom_range(17, 64)
			: $urandom_range(65, 300);
		sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(0, 15) == 0)
				read_mask(pick_index());
			r = $urandom_range(0, 99);
			if (r >= 65 && r < 80)
				sgn = 0;
			else if (r >= 80)
				sgn = (sgn == 0) ? (($urandom_range(0, 1) != 0) ? 1 : -1) : -sgn;
			append(make_sample(sgn), (k == n - 1) && ($urandom_range(0, 11) != 0));
		end
		nreads = $urandom_range(1, (n < 32) ? n + 3 : 32);
		for (k = 0; k < nreads; k++)
			read_mask(pick_index());
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_reply(masked, in_range, index_echo);
			if (in_valid && in_ready)
				sb.note_beat(operation, sample_value, last_sample, read_index);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			int gap;
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin
		logic signed [SAMPLE_BITS-1:0] rec [8];
		int k, goal, cfg_step, next_cfg;
		logic [THR_W-1:0] thr;
		sb = new();
		calm = 1'b0;
		beats_sent = 0;
		cfg_errors = 0;
		idle_cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		operation <= OP_APPEND;
		sample_value <= '0;
		last_sample <= 1'b0;
		read_index <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reads on an empty record, then one small record with both extremes
		read_mask('0);
		read_mask('1);
		set_threshold(THR_W'(100), 1'b1);
		rec = '{16'sd32767, 16'sd0, 16'sd5, -16'sd32768, -16'sd3, 16'sd0, 16'sd40, -16'sd1};
		for (k = 0; k < 8; k++) begin
			if (k == 3)
				read_mask(IDX_W'(1));
			append(rec[k], k == 7);
		end
		for (k = 0; k <= 8; k++)
			read_mask(IDX_W'(k));
		read_mask('1);

		// fill the store, then two appends past the end; the last one still starts a pass
		calm = 1'b1;
		for (k = 0; k < DEPTH; k++)
			append(make_sample($urandom_range(0, 2) - 1), 1'b0);
		append(make_sample(1), 1'b0);
		append(make_sample(-1), 1'b1);
		calm = 1'b0;
		read_mask('0);
		read_mask('1);
		for (k = 0; k < 8; k++)
			read_mask(IDX_W'($urandom));

		goal = beats_sent + RANDOM_BEATS;
		cfg_step = 0;
		next_cfg = beats_sent;
		while (beats_sent < goal) begin
			if (beats_sent >= next_cfg) begin
				case (cfg_step)
					0: thr = '0;
					1: thr = '1;
					2: thr = THR_RESET;
					default: thr = ($urandom_range(0, 1) != 0) ? THR_W'($urandom_range(1, 300))
						: THR_W'($urandom);
				endcase
				set_threshold(thr, $urandom_range(0, 2) == 0);
				cfg_step++;
				next_cfg = beats_sent + 150;
			end
			calm = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4)) read_mask(IDX_W'($urandom));
			else
				run_record();
		end
		calm = 1'b0;

		settle();
		$display("covered %0d beats in, %0d mask replies checked, %0d mask passes",
			beats_sent, sb.replies, sb.records);
		$display("%0d register writes, %0d appends dropped on a full store",
			sb.cfg_writes, sb.dropped);
		if (sb.errors + cfg_errors + sb.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== peak_region_zero_cross_mask.f =====
rtl/przcm_pkg.sv
rtl/peak_region_zero_cross_mask.sv
bench/tb.sv
